FILE: rtl/pid_position_with_velocity_clamp_macros.svh
// Assertion macros for the PID position controller
`ifndef PID_POSITION_WITH_VELOCITY_CLAMP_MACROS_SVH
`define PID_POSITION_WITH_VELOCITY_CLAMP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define PPV_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define PPV_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: rtl/ppv_pkg.sv
// ----------------------------------------------------------------------------
// ppv_pkg
// Shared types and helpers for the PID position controller.
// ----------------------------------------------------------------------------
package ppv_pkg;
    localparam int W = 32;
    localparam int MW = 64;
    localparam int DIVW = 56;

    localparam logic [2:0] CFG_KP = 3'd0;
    localparam logic [2:0] CFG_KI = 3'd1;
    localparam logic [2:0] CFG_KD = 3'd2;
    localparam logic [2:0] CFG_FC = 3'd3;
    localparam logic [2:0] CFG_TGT = 3'd4;
    localparam logic [2:0] CFG_VMAX = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_KD, ST_DSUB, ST_FC, ST_KP, ST_SUM,
        ST_KI, ST_IT, ST_FT, ST_UPD, ST_VWAIT, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic frac24;
    } mul_ctl_t;

    function automatic logic signed [W-1:0] sat32(input logic signed [MW+1:0] v);
        if (v > $signed({{(MW-W+2){1'b0}}, {1'b0, {(W-1){1'b1}}}}))
            return {1'b0, {(W-1){1'b1}}};
        else if (v < -$signed({{(MW-W+2){1'b0}}, {1'b1, {(W-1){1'b0}}}}))
            return {1'b1, {(W-1){1'b0}}};
        else
            return v[W-1:0];
    endfunction
endpackage

FILE: rtl/ppv_mul.sv
// ----------------------------------------------------------------------------
// ppv_mul
// Bit-serial signed 33x33 multiplier with floor shift and saturation.
// ----------------------------------------------------------------------------
module ppv_mul import ppv_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  mul_ctl_t            ctl,
    input  logic signed [W:0]   a,
    input  logic signed [W:0]   b,
    output logic                done,
    output logic signed [W-1:0] y
);
    logic signed [MW+1:0] acc_reg, acc_next;
    logic signed [MW+1:0] mcand_reg, mcand_next;
    logic [W:0] mplier_reg, mplier_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, frac_reg, frac_next;
    logic signed [MW+1:0] sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        frac_reg <= frac_next;
    end

    always_comb begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        frac_next = frac_reg;
        done = 1'b0;
        if (ctl.start) begin
            acc_next = '0;
            mcand_next = {{(MW-W+1){a[W]}}, a};
            mplier_next = b;
            cnt_next = '0;
            busy_next = 1'b1;
            frac_next = ctl.frac24;
        end else if (busy_reg) begin
            // two's complement: top bit of multiplier has negative weight
            if (mplier_reg[0]) begin
                if (cnt_reg == 6'(W)) acc_next = acc_reg - mcand_reg;
                else acc_next = acc_reg + mcand_reg;
            end
            mcand_next = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(W)) begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    always_comb begin
        if (frac_reg) sh = acc_next >>> 24;
        else sh = acc_next >>> 16;
        y = sat32(sh);
    end
endmodule

FILE: rtl/ppv_div.sv
// ----------------------------------------------------------------------------
// ppv_div
// Restoring radix-2 divider for the velocity command, with clamp.
// ----------------------------------------------------------------------------
module ppv_div import ppv_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] err,
    input  logic [W-1:0]        ts,
    input  logic [W-2:0]        vmax,
    output logic                done,
    output logic signed [W-1:0] vel
);
    logic [DIVW-1:0] q_reg, q_next;
    logic [W:0] rem_reg, rem_next;
    logic [W-1:0] d_reg, d_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, neg_reg, neg_next, zero_reg, zero_next;
    logic done_reg, done_next;
    logic [W:0] trial;
    logic [DIVW-1:0] mag;
    logic [W-1:0] magc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
        zero_reg <= zero_next;
    end

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        trial = {rem_reg[W-1:0], q_reg[DIVW-1]};
        if (start) begin
            neg_next = err[W-1];
            q_next = {(err[W-1] ? W'(-err) : W'(err)), 24'd0};
            rem_next = '0;
            d_next = ts;
            zero_next = (ts == '0);
            cnt_next = '0;
            busy_next = (ts != '0);
            done_next = (ts == '0);
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = trial - {1'b0, d_reg};
                q_next = {q_reg[DIVW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[DIVW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIVW-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb begin
        done = done_reg;
        mag = zero_reg ? ((q_reg != '0) ? DIVW'(vmax) : '0) : q_reg;
        if (mag > DIVW'(vmax)) magc = W'(vmax);
        else magc = mag[W-1:0];
        vel = neg_reg ? -$signed(magc) : $signed(magc);
    end
endmodule

FILE: rtl/pid_position_with_velocity_clamp.sv
// ----------------------------------------------------------------------------
// pid_position_with_velocity_clamp
// PID position controller with filtered derivative and clamped velocity.
// ----------------------------------------------------------------------------
// Use: write gains, filter coefficient, target and velocity limit on the
// cfg channel (cfg_index 0..5) while idle. Each s_ item carries time_step
// (Q8.24) and measured_pos (Q16.16); one m_ item carries cmd_pos and cmd_vel.
// One item is in flight at a time. s_ready is high in the idle state only.
// Six products go through one bit-serial multiplier in turn, between the
// error, derivative-subtract, sum and update steps; the 56-step divider
// runs alongside them, started in the error step.
// Reset clears the gains, the integrator and the filter state.
// A stalled receiver holds m_valid and the result; the next item is taken
// once the result has gone.
// ----------------------------------------------------------------------------
`include "pid_position_with_velocity_clamp_macros.svh"
module pid_position_with_velocity_clamp import ppv_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [W-1:0]        cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [W-1:0]        s_time_step,
    input  logic signed [W-1:0] s_measured_pos,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [W-1:0] m_cmd_pos,
    output logic signed [W-1:0] m_cmd_vel
);
    state_t state_reg, state_next;
    logic signed [W-1:0] kp_reg, ki_reg, kd_reg, fc_reg, tgt_reg;
    logic [W-2:0] vmax_reg;
    logic signed [W-1:0] integ_reg, integ_next, filt_reg, filt_next;
    logic [W-1:0] ts_reg;
    logic signed [W-1:0] pos_reg, err_reg, err_next, t_reg, t_next;
    logic signed [W-1:0] d_reg, d_next, cp_reg, cp_next, ii_reg, ii_next;
    logic signed [W-1:0] vel_reg, vel_next, cpos_reg, cpos_next;
    logic vdone_reg, vdone_next;
    logic mul_pend_reg, mul_pend_next;
    mul_ctl_t mctl;
    logic signed [W:0] ma, mb;
    logic mdone, ddone, dstart;
    logic signed [W-1:0] my, dvel;

    ppv_mul u_mul (.aclk, .aresetn, .ctl(mctl), .a(ma), .b(mb), .done(mdone), .y(my));
    ppv_div u_div (.aclk, .aresetn, .start(dstart), .err(err_next), .ts(ts_reg),
                   .vmax(vmax_reg), .done(ddone), .vel(dvel));

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_cmd_pos = cpos_reg;
    assign m_cmd_vel = vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kp_reg <= '0; ki_reg <= '0; kd_reg <= '0; fc_reg <= '0; tgt_reg <= '0;
            vmax_reg <= '0;
            integ_reg <= '0;
            filt_reg <= '0;
            vdone_reg <= 1'b0;
            mul_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            filt_reg <= filt_next;
            vdone_reg <= vdone_next;
            mul_pend_reg <= mul_pend_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_KP: kp_reg <= cfg_data;
                    CFG_KI: ki_reg <= cfg_data;
                    CFG_KD: kd_reg <= cfg_data;
                    CFG_FC: fc_reg <= cfg_data;
                    CFG_TGT: tgt_reg <= cfg_data;
                    CFG_VMAX: vmax_reg <= cfg_data[W-2:0];
                    default: ;
                endcase
            end
        end
        if (s_valid && s_ready) begin
            ts_reg <= s_time_step;
            pos_reg <= s_measured_pos;
        end
        err_reg <= err_next;
        t_reg <= t_next;
        d_reg <= d_next;
        cp_reg <= cp_next;
        ii_reg <= ii_next;
        vel_reg <= vel_next;
        cpos_reg <= cpos_next;
    end

    // sequencer: one product at a time through the shared multiplier
    always_comb begin
        state_next = state_reg;
        integ_next = integ_reg;
        filt_next = filt_reg;
        err_next = err_reg;
        t_next = t_reg;
        d_next = d_reg;
        cp_next = cp_reg;
        ii_next = ii_reg;
        vel_next = vel_reg;
        cpos_next = cpos_reg;
        vdone_next = vdone_reg;
        mul_pend_next = mul_pend_reg;
        mctl = '{start: 1'b0, frac24: 1'b0};
        ma = '0;
        mb = '0;
        dstart = 1'b0;
        if (ddone) begin
            vel_next = dvel;
            vdone_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_ERR;
            end
            ST_ERR: begin
                err_next = sat32(66'(tgt_reg) - 66'(pos_reg));
                dstart = 1'b1;
                vdone_next = 1'b0;
                state_next = ST_KD;
            end
            ST_KD, ST_FC, ST_KP, ST_KI, ST_IT, ST_FT: begin
                case (state_reg)
                    ST_KD: begin ma = {kd_reg[W-1], kd_reg}; mb = {err_reg[W-1], err_reg}; end
                    ST_FC: begin ma = {t_reg[W-1], t_reg}; mb = {fc_reg[W-1], fc_reg}; end
                    ST_KP: begin ma = {kp_reg[W-1], kp_reg}; mb = {err_reg[W-1], err_reg}; end
                    ST_KI: begin ma = {ki_reg[W-1], ki_reg}; mb = {err_reg[W-1], err_reg}; end
                    ST_IT: begin ma = {ii_reg[W-1], ii_reg}; mb = {1'b0, ts_reg}; end
                    default: begin ma = {d_reg[W-1], d_reg}; mb = {1'b0, ts_reg}; end
                endcase
                if (!mul_pend_reg) begin
                    mctl = '{start: 1'b1,
                             frac24: (state_reg == ST_IT) || (state_reg == ST_FT)};
                    mul_pend_next = 1'b1;
                end else if (mdone) begin
                    mul_pend_next = 1'b0;
                    case (state_reg)
                        ST_KD: begin t_next = my; state_next = ST_DSUB; end
                        ST_FC: begin d_next = my; state_next = ST_KP; end
                        ST_KP: begin cp_next = my; state_next = ST_SUM; end
                        ST_KI: begin ii_next = my; state_next = ST_IT; end
                        ST_IT: begin ii_next = my; state_next = ST_FT; end
                        default: begin t_next = my; state_next = ST_UPD; end
                    endcase
                end
            end
            ST_DSUB: begin
                t_next = sat32(66'(t_reg) - 66'(filt_reg));
                state_next = ST_FC;
            end
            ST_SUM: begin
                cpos_next = sat32(66'(cp_reg) + 66'(integ_reg) + 66'(d_reg));
                state_next = ST_KI;
            end
            ST_UPD: begin
                integ_next = sat32(66'(integ_reg) + 66'(ii_reg));
                filt_next = sat32(66'(filt_reg) + 66'(t_reg));
                state_next = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (vdone_reg || ddone) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `PPV_ASSERT_IMP(a_excl, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `PPV_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
                     m_valid && $stable(m_cmd_pos) && $stable(m_cmd_vel))
    `PPV_ASSERT_NEXT(a_state, aclk, aresetn, s_valid && s_ready,
                     !s_ready && !m_valid && $stable(integ_reg))
endmodule
